@@ rtl/e2q_pkg.sv @@
// Package for the Euler angle to quaternion converter.
// Shared widths, types, default parameter values and the CORDIC arctangent table.
// Depends on nothing.
package e2q_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF   = 8;
   localparam int COMP_FRAC_DEF    = 14;

   localparam int IN_W   = 18;   // angle field width
   localparam int OUT_W  = 16;   // component field width
   localparam int CW     = 32;   // CORDIC x/y width
   localparam int ZW     = 34;   // CORDIC angle accumulator width
   localparam int QCW    = 34;   // raw quaternion component width
   localparam int SUM_W  = 64;   // sum of squares width
   localparam int MAG_W  = 32;   // magnitude width
   localparam int LANES  = 4;    // x, y, z, w
   localparam int ATAN_LEN = 24;

   localparam longint DEG_TO_RAD_Q30 = 18740330;

   typedef logic signed [IN_W-1:0]  angle_type;
   typedef logic signed [QCW-1:0]   comp_type;
   typedef logic [OUT_W-1:0]        out_type;

   typedef struct packed {
      logic signed [CW-1:0] s;
      logic signed [CW-1:0] c;
   } sincos_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = ZW'(843314856);
         1:  r = ZW'(497837829);
         2:  r = ZW'(263043836);
         3:  r = ZW'(133525158);
         4:  r = ZW'(67021686);
         5:  r = ZW'(33543515);
         6:  r = ZW'(16775850);
         7:  r = ZW'(8388437);
         8:  r = ZW'(4194282);
         9:  r = ZW'(2097149);
         10: r = ZW'(1048575);
         11: r = ZW'(524287);
         12: r = ZW'(262143);
         13: r = ZW'(131071);
         14: r = ZW'(65535);
         15: r = ZW'(32767);
         16: r = ZW'(16383);
         17: r = ZW'(8191);
         18: r = ZW'(4095);
         19: r = ZW'(2047);
         20: r = ZW'(1023);
         21: r = ZW'(511);
         22: r = ZW'(255);
         23: r = ZW'(127);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/e2q_cordic.sv @@
// Three-lane angle reduction and unrolled CORDIC giving sine/cosine of each half angle.
// Registered: product, remainder, fold, start, each step, output. Depends on e2q_pkg.
module e2q_cordic
   import e2q_pkg::*;
#(
   parameter int STEPS      = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC = ANGLE_FRAC_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  angle_type  angle [3],
   output logic       out_valid,
   output sincos_type sc [3]
);

   localparam longint HALF    = longint'(180) << (ANGLE_FRAC + 1);
   localparam longint TURN    = 2 * HALF;
   localparam longint QUARTER = HALF / 2;
   localparam longint OFFS    = ((longint'(1) << (IN_W - 1)) + TURN - 1) / TURN * TURN + HALF;
   localparam int     RSH     = 40;
   localparam longint RECIP   = ((longint'(1) << RSH) + TURN - 1) / TURN;
   localparam logic signed [CW-1:0] X0 = CW'(1 << 29);

   logic                 v1_ff, v2_ff, v3_ff;
   logic [31:0]          u1_in [3];
   logic [63:0]          p1_in [3];
   logic [31:0]          u1_ff [3];
   logic [63:0]          p1_ff [3];
   logic signed [31:0]   r2_in [3];
   logic signed [31:0]   r2_ff [3];
   logic signed [31:0]   r3_in [3];
   logic                 n3_in [3];
   logic signed [31:0]   r3_ff [3];
   logic                 n3_ff [3];
   logic signed [ZW-1:0] z0_in [3];

   logic                 vc_ff [STEPS+1];
   logic signed [CW-1:0] x_ff  [STEPS+1][3];
   logic signed [CW-1:0] y_ff  [STEPS+1][3];
   logic signed [ZW-1:0] z_ff  [STEPS+1][3];
   logic                 nc_ff [STEPS+1][3];

   logic                 vo_ff;
   sincos_type           sc_ff [3];

   // offset to a positive value, then quotient by one turn via reciprocal
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u1_in[k] = 32'(longint'(angle[k]) + OFFS);
         p1_in[k] = 64'(u1_in[k]) * 64'(32'(RECIP));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r2_in[k] = 32'(longint'(u1_ff[k]) - longint'(p1_ff[k] >> RSH) * TURN - HALF);
      end
   end

   // fold into [-90, 90] degrees
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (longint'(r2_ff[k]) > QUARTER) begin
            r3_in[k] = 32'(longint'(r2_ff[k]) - HALF);
            n3_in[k] = 1'b1;
         end else if (longint'(r2_ff[k]) < -QUARTER) begin
            r3_in[k] = 32'(longint'(r2_ff[k]) + HALF);
            n3_in[k] = 1'b1;
         end else begin
            r3_in[k] = r2_ff[k];
            n3_in[k] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         z0_in[k] = ZW'((longint'(r3_ff[k]) * DEG_TO_RAD_Q30) >>> (ANGLE_FRAC + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         vc_ff[0] <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vc_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            u1_ff[k]    <= u1_in[k];
            p1_ff[k]    <= p1_in[k];
            r2_ff[k]    <= r2_in[k];
            r3_ff[k]    <= r3_in[k];
            n3_ff[k]    <= n3_in[k];
            x_ff[0][k]  <= X0;
            y_ff[0][k]  <= '0;
            z_ff[0][k]  <= z0_in[k];
            nc_ff[0][k] <= n3_ff[k];
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[i+1] <= 1'b0;
         end else if (en) begin
            vc_ff[i+1] <= vc_ff[i];
         end
      end

      for (genvar k = 0; k < 3; k++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               nc_ff[i+1][k] <= nc_ff[i][k];
               if (!z_ff[i][k][ZW-1]) begin
                  x_ff[i+1][k] <= x_ff[i][k] - (y_ff[i][k] >>> i);
                  y_ff[i+1][k] <= y_ff[i][k] + (x_ff[i][k] >>> i);
                  z_ff[i+1][k] <= z_ff[i][k] - atan_q30(i);
               end else begin
                  x_ff[i+1][k] <= x_ff[i][k] + (y_ff[i][k] >>> i);
                  y_ff[i+1][k] <= y_ff[i][k] - (x_ff[i][k] >>> i);
                  z_ff[i+1][k] <= z_ff[i][k] + atan_q30(i);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vc_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sc_ff[k].s <= nc_ff[STEPS][k] ? -y_ff[STEPS][k] : y_ff[STEPS][k];
            sc_ff[k].c <= nc_ff[STEPS][k] ? -x_ff[STEPS][k] : x_ff[STEPS][k];
         end
      end
   end

   assign out_valid = vo_ff;
   assign sc        = sc_ff;

endmodule

@@ rtl/e2q_quat.sv @@
// Quaternion products from half-angle sines/cosines, then sum of squares.
// Six register stages. Depends on e2q_pkg.
module e2q_quat
   import e2q_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  sincos_type       sc [3],
   output logic             out_valid,
   output comp_type         comp [LANES],
   output logic [SUM_W-1:0] sum
);

   localparam int PW = 2 * CW - 30;
   localparam int MW = PW + CW;

   // lane order: pitch 0, heading 1, bank 2; products cc, ss, cs, sc
   logic                   v_ff [6];
   logic signed [2*CW-1:0] p1_ff [4];
   logic signed [PW-1:0]   a2    [4];
   logic signed [MW-1:0]   m2_ff [8];
   logic signed [CW-1:0]   cb2_ff, sb2_ff;
   comp_type               q3_ff [LANES];
   comp_type               q4_ff [LANES];
   comp_type               q5_ff [LANES];
   comp_type               q6_ff [LANES];
   logic [SUM_W-1:0]       sq4_ff [LANES];
   logic [SUM_W-1:0]       s5_ff [2];
   logic [SUM_W-1:0]       s6_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a2[k] = PW'(p1_ff[k] >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < 6; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= sc[1].c * sc[0].c;
         p1_ff[1] <= sc[1].s * sc[0].s;
         p1_ff[2] <= sc[1].c * sc[0].s;
         p1_ff[3] <= sc[1].s * sc[0].c;
         cb2_ff   <= sc[2].c;
         sb2_ff   <= sc[2].s;

         m2_ff[0] <= a2[0] * cb2_ff;   // w
         m2_ff[1] <= a2[1] * sb2_ff;
         m2_ff[2] <= a2[2] * cb2_ff;   // x
         m2_ff[3] <= a2[3] * sb2_ff;
         m2_ff[4] <= a2[3] * cb2_ff;   // y
         m2_ff[5] <= a2[2] * sb2_ff;
         m2_ff[6] <= a2[0] * sb2_ff;   // z
         m2_ff[7] <= a2[1] * cb2_ff;

         q3_ff[0] <= QCW'((m2_ff[2] >>> 30) + (m2_ff[3] >>> 30));
         q3_ff[1] <= QCW'((m2_ff[4] >>> 30) - (m2_ff[5] >>> 30));
         q3_ff[2] <= QCW'((m2_ff[6] >>> 30) - (m2_ff[7] >>> 30));
         q3_ff[3] <= QCW'((m2_ff[0] >>> 30) + (m2_ff[1] >>> 30));

         for (int k = 0; k < LANES; k++) begin
            sq4_ff[k] <= SUM_W'(q3_ff[k] * q3_ff[k]);
            q4_ff[k]  <= q3_ff[k];
            q5_ff[k]  <= q4_ff[k];
            q6_ff[k]  <= q5_ff[k];
         end
         s5_ff[0] <= sq4_ff[0] + sq4_ff[1];
         s5_ff[1] <= sq4_ff[2] + sq4_ff[3];
         s6_ff    <= s5_ff[0] + s5_ff[1];
      end
   end

   assign out_valid = v_ff[5];
   assign comp      = q6_ff;
   assign sum       = s6_ff;

endmodule

@@ rtl/e2q_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, 32 stages.
// Carries the quaternion components alongside. Depends on e2q_pkg.
module e2q_sqrt
   import e2q_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  comp_type         comp_in [LANES],
   input  logic [SUM_W-1:0] sum,
   output logic             out_valid,
   output comp_type         comp_out [LANES],
   output logic [MAG_W-1:0] mag
);

   localparam int NST = SUM_W / 2;

   logic             v_ff [NST];
   logic [SUM_W-1:0] n_ff [NST];
   logic [SUM_W-1:0] r_ff [NST];
   comp_type         c_ff [NST][LANES];

   for (genvar k = 0; k < NST; k++) begin : g_st
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

      logic             v_src;
      logic [SUM_W-1:0] n_src, r_src, t;
      comp_type         c_src [LANES];

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign n_src = sum;
         assign r_src = '0;
         assign c_src = comp_in;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign n_src = n_ff[k-1];
         assign r_src = r_ff[k-1];
         assign c_src = c_ff[k-1];
      end

      assign t = r_src + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[k] <= c_src;
            if (n_src >= t) begin
               n_ff[k] <= n_src - t;
               r_ff[k] <= (r_src >> 1) + BIT;
            end else begin
               n_ff[k] <= n_src;
               r_ff[k] <= r_src >> 1;
            end
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign comp_out  = c_ff[NST-1];
   assign mag       = r_ff[NST-1][MAG_W-1:0];

endmodule

@@ rtl/e2q_div.sv @@
// Normalizing divider: rounded restoring division of each component by the magnitude,
// one quotient bit per stage, then saturation. Depends on e2q_pkg.
module e2q_div
   import e2q_pkg::*;
#(
   parameter int FRAC = COMP_FRAC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  comp_type         comp [LANES],
   input  logic [MAG_W-1:0] mag,
   output logic             out_valid,
   output out_type          quat [LANES]
);

   localparam int QW = FRAC + 1;
   localparam int DW = QCW + FRAC;
   localparam logic [QW-1:0] ONE   = QW'(1) << FRAC;
   localparam logic [31:0]   ONE32 = 32'(ONE);

   logic             v_ff    [QW+1];
   logic [DW-1:0]    rem_ff  [QW+1][LANES];
   logic [QW-1:0]    q_ff    [QW+1][LANES];
   logic             neg_ff  [QW+1][LANES];
   logic [MAG_W-1:0] m_ff    [QW+1];
   logic             zero_ff [QW+1];
   logic [QCW-1:0]   abs_in  [LANES];

   logic             vo_ff;
   out_type          o_ff [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         abs_in[k] = comp[k][QCW-1] ? QCW'(-comp[k]) : QCW'(comp[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= mag;
         zero_ff[0] <= (mag == '0);
         for (int k = 0; k < LANES; k++) begin
            rem_ff[0][k] <= (DW'(abs_in[k]) << FRAC) + DW'(mag >> 1);
            q_ff[0][k]   <= '0;
            neg_ff[0][k] <= comp[k][QCW-1];
         end
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_bit
      localparam int SH = QW - 1 - j;

      logic [DW-1:0] dsh;
      assign dsh = DW'(m_ff[j]) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j+1]    <= m_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            for (int k = 0; k < LANES; k++) begin
               neg_ff[j+1][k] <= neg_ff[j][k];
               if (rem_ff[j][k] >= dsh) begin
                  rem_ff[j+1][k] <= rem_ff[j][k] - dsh;
                  q_ff[j+1][k]   <= {q_ff[j][k][QW-2:0], 1'b1};
               end else begin
                  rem_ff[j+1][k] <= rem_ff[j][k];
                  q_ff[j+1][k]   <= {q_ff[j][k][QW-2:0], 1'b0};
               end
            end
         end
      end
   end

   logic [31:0] qs32 [LANES];
   out_type     o_in [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         qs32[k] = (q_ff[QW][k] > ONE) ? ONE32 : 32'(q_ff[QW][k]);
         if (zero_ff[QW]) begin
            o_in[k] = (k == LANES - 1) ? ONE32[OUT_W-1:0] : '0;
         end else if (neg_ff[QW][k]) begin
            o_in[k] = OUT_W'(32'd0 - qs32[k]);
         end else begin
            o_in[k] = qs32[k][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = vo_ff;
   assign quat      = o_ff;

endmodule

@@ rtl/euler_to_quaternion.sv @@
// Euler angles (pitch, heading, bank) to normalized rotation quaternion.
// The pipeline runs through the CORDIC steps, 32 square-root stages and one divider stage
// per quotient bit. Throughput one beat per clock while req_stall is low; a two-entry
// output stage takes the pipeline's beat while the head beat waits, req_stall rises only
// when both entries hold beats.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS     = ANGLE_FRAC_DEF,
   parameter int COMPONENT_FRAC_BITS = COMP_FRAC_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  angle_type req_pitch_deg,
   input  angle_type req_heading_deg,
   input  angle_type req_bank_deg,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output out_type   rsp_quat_x,
   output out_type   rsp_quat_y,
   output out_type   rsp_quat_z,
   output out_type   rsp_quat_w
);

   logic             en;
   angle_type        angle [3];
   logic             cv, qv, sv, pv;
   sincos_type       sc [3];
   comp_type         qc [LANES];
   comp_type         sc_comp [LANES];
   logic [SUM_W-1:0] sum;
   logic [MAG_W-1:0] mag;
   out_type          pq [LANES];

   logic             out_valid_ff, skid_valid_ff, out_free;
   out_type          out_ff  [LANES];
   out_type          skid_ff [LANES];

   assign angle[0] = req_pitch_deg;
   assign angle[1] = req_heading_deg;
   assign angle[2] = req_bank_deg;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   e2q_cordic #(
      .STEPS      (CORDIC_STEPS),
      .ANGLE_FRAC (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .angle     (angle),
      .out_valid (cv),
      .sc        (sc)
   );

   e2q_quat u_quat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cv),
      .sc        (sc),
      .out_valid (qv),
      .comp      (qc),
      .sum       (sum)
   );

   e2q_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (qv),
      .comp_in   (qc),
      .sum       (sum),
      .out_valid (sv),
      .comp_out  (sc_comp),
      .mag       (mag)
   );

   e2q_div #(
      .FRAC (COMPONENT_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .comp      (sc_comp),
      .mag       (mag),
      .out_valid (pv),
      .quat      (pq)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_valid_ff <= pv;
      end else if (pv) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff <= skid_ff;
         end
      end else if (out_free) begin
         out_ff <= pq;
      end else begin
         skid_ff <= pq;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_quat_x = out_ff[0];
   assign rsp_quat_y = out_ff[1];
   assign rsp_quat_z = out_ff[2];
   assign rsp_quat_w = out_ff[3];

endmodule

@@ rtl/e2q_checker.sv @@
// Port-level checks for euler_to_quaternion, attached by bind.
// Depends on e2q_pkg and the top level's ports.
module e2q_checker
   import e2q_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input out_type rsp_quat_x
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled beat dropped");

   a_stall_needs_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no beat at output");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |=> !req_stall)
      else $error("input still stalled after output drained");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_quat_x))
      else $error("stalled beat changed");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_quat_x (rsp_quat_x)
);

@@ dv/tb_euler_to_quaternion.sv @@
// Testbench for euler_to_quaternion: directed table then random angle triples, each
// checked against table values or a fixed-point predictor under random stalls/gaps.
// Depends on e2q_pkg and rtl/euler_to_quaternion.sv.
module tb_euler_to_quaternion;
   import e2q_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int AFB   = ANGLE_FRAC_DEF;
   localparam int CFB   = COMP_FRAC_DEF;
   localparam int N_RANDOM = 1625;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      angle_type p, h, b;
      logic      known;
      out_type   qx, qy, qz, qw;
   } row_type;

   typedef struct {
      out_type qx, qy, qz, qw;
   } quat_type;

   logic      clock = 0;
   logic      reset = 1;
   logic      req_valid = 0;
   logic      req_stall;
   angle_type req_pitch_deg = '0, req_heading_deg = '0, req_bank_deg = '0;
   logic      rsp_valid;
   logic      rsp_stall = 0;
   out_type   rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   quat_type quat_queue[$];
   int       errors = 0;
   longint   cycles = 0;
   row_type  dir_rows[$];

   euler_to_quaternion DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void half_sin_cos(longint hin, output longint s, output longint c);
      longint half, turn, quarter, r, x, y, z, xs, ys;
      bit     neg;
      half = longint'(180) << (AFB + 1);
      turn = half * 2;
      quarter = half / 2;
      neg = 0;
      r = hin % turn;
      if (r >= half) r -= turn;
      if (r < -half) r += turn;
      if (r > quarter) begin
         r -= half; neg = 1;
      end else if (r < -quarter) begin
         r += half; neg = 1;
      end
      z = asr(r * DEG_TO_RAD_Q30, AFB + 1);
      x = longint'(1) << 29;
      y = 0;
      for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
         longint a;
         a = atan_q30(i);
         xs = asr(x, i);
         ys = asr(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= a;
         end else begin
            x += ys; y -= xs; z += a;
         end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
   endfunction

   function automatic longint prod3(longint a, longint b, longint c);
      return asr(asr(a * b, 30) * c, 30);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic out_type scale_comp(longint comp, longint unsigned m);
      longint unsigned mag, q;
      longint v;
      mag = comp < 0 ? -comp : comp;
      q = ((mag << CFB) + m / 2) / m;
      v = (q > (64'd1 << CFB)) ? (longint'(1) << CFB) : longint'(q);
      if (comp < 0) v = -v;
      return out_type'(v);
   endfunction

   function automatic quat_type predict_quat(angle_type p, angle_type h, angle_type b);
      longint sp, cp, sh, ch, sb, cb, qx, qy, qz, qw;
      longint unsigned sum, m;
      quat_type r;
      half_sin_cos(longint'(p), sp, cp);
      half_sin_cos(longint'(h), sh, ch);
      half_sin_cos(longint'(b), sb, cb);
      qw = prod3(ch, cp, cb) + prod3(sh, sp, sb);
      qx = prod3(ch, sp, cb) + prod3(sh, cp, sb);
      qy = prod3(sh, cp, cb) - prod3(ch, sp, sb);
      qz = prod3(ch, cp, sb) - prod3(sh, sp, cb);
      sum = qx * qx + qy * qy + qz * qz + qw * qw;
      m = int_sqrt(sum);
      if (m == 0) begin
         r.qx = '0; r.qy = '0; r.qz = '0; r.qw = out_type'(1 << CFB);
      end else begin
         r.qx = scale_comp(qx, m);
         r.qy = scale_comp(qy, m);
         r.qz = scale_comp(qz, m);
         r.qw = scale_comp(qw, m);
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, out_type got, out_type want);
      $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   function automatic angle_type rand_angle();
      case ($urandom_range(0, 5))
         0: return angle_type'($urandom_range(0, 2) * 180 * 256 - 46080);
         1: return angle_type'(int'($urandom_range(0, 4)) * 23040 - 46080);
         2: return $urandom_range(0, 1) ? angle_type'(18'h1FFFF) : angle_type'(18'h20000);
         default: return angle_type'($urandom);
      endcase
   endfunction

   // response side
   initial begin
      int gap;
      quat_type want;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (quat_queue.size() == 0) begin
            $display("unexpected beat at cycle %0d", cycles);
            errors++;
         end else begin
            want = quat_queue.pop_front();
            if (rsp_quat_x !== want.qx) report_mismatch("quat_x", rsp_quat_x, want.qx);
            if (rsp_quat_y !== want.qy) report_mismatch("quat_y", rsp_quat_y, want.qy);
            if (rsp_quat_z !== want.qz) report_mismatch("quat_z", rsp_quat_z, want.qz);
            if (rsp_quat_w !== want.qw) report_mismatch("quat_w", rsp_quat_w, want.qw);
         end
      end
   end

   task automatic send_angles(angle_type p, angle_type h, angle_type b, quat_type want);
      int gap;
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pitch_deg <= p;
      req_heading_deg <= h;
      req_bank_deg <= b;
      do @(posedge clock); while (req_stall);
      quat_queue.push_back(want);
   endtask

   task automatic add_row(angle_type p, angle_type h, angle_type b, logic known,
                          out_type qx = 0, out_type qy = 0, out_type qz = 0, out_type qw = 0);
      row_type r;
      r.p = p; r.h = h; r.b = b; r.known = known;
      r.qx = qx; r.qy = qy; r.qz = qz; r.qw = qw;
      dir_rows.push_back(r);
   endtask

   initial begin
      quat_type want;
      // identity, then 360 deg about each axis (sign flip of w)
      add_row(0, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
      add_row(360 * 256, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
      add_row(0, 360 * 256, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
      add_row(0, 0, 360 * 256, 1, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
      add_row(-360 * 256, -360 * 256, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
      add_row(180 * 256, 0, 0, 0);
      add_row(0, 180 * 256, 0, 0);
      add_row(0, 0, 180 * 256, 0);
      add_row(-180 * 256, -180 * 256, -180 * 256, 0);
      add_row(90 * 256, 0, 0, 0);
      add_row(0, -90 * 256, 0, 0);
      add_row(0, 0, 90 * 256, 0);
      add_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);
      add_row(18'h20000, 18'h20000, 18'h20000, 0);
      add_row(18'h1FFFF, 18'h20000, 0, 0);
      add_row(1, -1, 1, 0);
      add_row(-1, 1, -1, 0);
      add_row(30 * 256, 45 * 256, 60 * 256, 0);
      add_row(540 * 256, -540 * 256, 270 * 256, 0);
      add_row(18'h15555, 18'h2AAAA, 18'h00FF0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].known) begin
            want.qx = dir_rows[i].qx; want.qy = dir_rows[i].qy;
            want.qz = dir_rows[i].qz; want.qw = dir_rows[i].qw;
         end else want = predict_quat(dir_rows[i].p, dir_rows[i].h, dir_rows[i].b);
         send_angles(dir_rows[i].p, dir_rows[i].h, dir_rows[i].b, want);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         angle_type p, h, b;
         p = rand_angle(); h = rand_angle(); b = rand_angle();
         send_angles(p, h, b, predict_quat(p, h, b));
      end
      req_valid <= 1'b0;

      while (quat_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && quat_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
